// File: rtl/core/ffha_pkg.sv
package ffha_pkg;

	// Command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Fixed field widths
	localparam int REQ_W  = 16;
	localparam int ADDR_W = 10;
	// Rounded request: up to 2**REQ_W, so one bit more
	localparam int WANT_W = REQ_W + 1;

	// Payload granule and smallest payload worth splitting off
	localparam int GRANULE_MASK = 7;
	localparam int MIN_SPLIT    = 8;

	// Flags from the header evaluation unit
	typedef struct packed {
		logic fit;      // entry is free and large enough
		logic split;    // leftover can hold a header plus a minimal payload
		logic nxt_in;   // next block header lies inside the heap
		logic rest_in;  // split-off header lies inside the heap
	} ffha_flags_t;

endpackage

// File: rtl/core/first_fit_heap_allocator_top.sv
// Allocate: setup reads the first header, the walk evaluates one header per cycle from
// the header memory, then the allocated and split-off headers are written; a failed walk
// goes straight to the result. Free reads its own header, absorbs each directly following
// free block, then writes the merged header; null and rejected frees and zero-size allocates
// go straight to the result. One item at a time. Reset: asynchronous; INIT then writes
// the initial free header, with in_stall high. Output register is emptied by reset.
module first_fit_heap_allocator_top #(
	parameter int HEAP_BYTES   = 1024,
	parameter int HEADER_BYTES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        command,
	input  logic [ffha_pkg::REQ_W-1:0]  request_size,
	input  logic [ffha_pkg::ADDR_W-1:0] block_address,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ffha_pkg::ADDR_W-1:0] payload_address,
	output logic                        success
);
	import ffha_pkg::*;

	localparam int PW    = $clog2(HEAP_BYTES) + 2;
	localparam int SW    = $clog2(HEAP_BYTES + 1);
	localparam int DEPTH = HEAP_BYTES / 8;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = (PW > WANT_W) ? PW : WANT_W;

	logic                res_valid;
	logic                res_stall;
	logic [ADDR_W-1:0]   res_addr;
	logic                res_ok;

	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [SW:0]         mem_wdata;
	logic [AW-1:0]       mem_raddr;
	logic [SW:0]         mem_rdata;

	logic [PW-1:0]       u_pos;
	logic [SW-1:0]       u_size_a;
	logic [SW-1:0]       u_rsize;
	logic                u_rfree;
	logic [WANT_W-1:0]   u_want;
	logic [CW-1:0]       u_want_split;
	logic [PW-1:0]       u_nxt_pos;
	logic [PW-1:0]       u_rest_pos;
	logic [SW-1:0]       u_rest_size;
	logic [SW-1:0]       u_grown;
	ffha_flags_t         u_flags;

	logic                out_valid_q;
	logic [ADDR_W-1:0]   payload_address_q;
	logic                success_q;

	ffha_ram #(
		.WIDTH(SW + 1),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	ffha_unit #(
		.HEAP_BYTES  (HEAP_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) u_unit (
		.pos       (u_pos),
		.size_a    (u_size_a),
		.rsize     (u_rsize),
		.rfree     (u_rfree),
		.want      (u_want),
		.want_split(u_want_split),
		.nxt_pos   (u_nxt_pos),
		.rest_pos  (u_rest_pos),
		.rest_size (u_rest_size),
		.grown     (u_grown),
		.flags     (u_flags)
	);

	ffha_ctrl #(
		.HEAP_BYTES  (HEAP_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.request_size (request_size),
		.block_address(block_address),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res_addr     (res_addr),
		.res_ok       (res_ok),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata),
		.u_pos        (u_pos),
		.u_size_a     (u_size_a),
		.u_rsize      (u_rsize),
		.u_rfree      (u_rfree),
		.u_want       (u_want),
		.u_want_split (u_want_split),
		.u_nxt_pos    (u_nxt_pos),
		.u_rest_pos   (u_rest_pos),
		.u_rest_size  (u_rest_size),
		.u_grown      (u_grown),
		.u_flags      (u_flags)
	);

	// Hold the result while the output stage is full and stalled
	assign res_stall = out_valid_q && out_stall;

	// Output register: load a finished result, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && !res_stall) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && !res_stall) begin
			payload_address_q <= res_addr;
			success_q         <= res_ok;
		end
	end

	assign out_valid       = out_valid_q;
	assign payload_address = payload_address_q;
	assign success         = success_q;

endmodule

// File: rtl/core/ffha_ram.sv
module ffha_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/ffha_unit.sv
module ffha_unit #(
	parameter int HEAP_BYTES   = 1024,
	parameter int HEADER_BYTES = 16
) (
	input  logic [$clog2(HEAP_BYTES)+1:0]   pos,
	input  logic [$clog2(HEAP_BYTES+1)-1:0] size_a,
	input  logic [$clog2(HEAP_BYTES+1)-1:0] rsize,
	input  logic                            rfree,
	input  logic [ffha_pkg::WANT_W-1:0]     want,
	input  logic [((($clog2(HEAP_BYTES)+2) > ffha_pkg::WANT_W) ?
		($clog2(HEAP_BYTES)+2) : ffha_pkg::WANT_W)-1:0] want_split,
	output logic [$clog2(HEAP_BYTES)+1:0]   nxt_pos,
	output logic [$clog2(HEAP_BYTES)+1:0]   rest_pos,
	output logic [$clog2(HEAP_BYTES+1)-1:0] rest_size,
	output logic [$clog2(HEAP_BYTES+1)-1:0] grown,
	output ffha_pkg::ffha_flags_t           flags
);
	import ffha_pkg::*;

	localparam int PW = $clog2(HEAP_BYTES) + 2;
	localparam int SW = $clog2(HEAP_BYTES + 1);
	localparam int CW = (PW > WANT_W) ? PW : WANT_W;

	logic [CW-1:0] nxt_sum;
	logic [CW-1:0] rest_sum;
	logic [CW-1:0] rest_len;
	logic [CW-1:0] grow_sum;

	// Header walk: next block, split point and merged size
	always_comb begin
		nxt_sum  = CW'(pos) + CW'(HEADER_BYTES) + CW'(size_a);
		rest_sum = CW'(pos) + CW'(HEADER_BYTES) + CW'(want);
		rest_len = CW'(rsize) - CW'(want) - CW'(HEADER_BYTES);
		grow_sum = CW'(size_a) + CW'(HEADER_BYTES) + CW'(rsize);
	end

	assign nxt_pos   = PW'(nxt_sum);
	assign rest_pos  = PW'(rest_sum);
	assign rest_size = SW'(rest_len);
	assign grown     = (grow_sum > CW'(HEAP_BYTES)) ? SW'(HEAP_BYTES) : SW'(grow_sum);

	// Compare flags
	always_comb begin
		flags.fit     = rfree && (CW'(rsize) >= CW'(want));
		flags.split   = CW'(rsize) >= want_split;
		flags.nxt_in  = nxt_sum < CW'(HEAP_BYTES);
		flags.rest_in = rest_sum < CW'(HEAP_BYTES);
	end

endmodule

// File: rtl/core/ffha_ctrl.sv
module ffha_ctrl #(
	parameter int HEAP_BYTES   = 1024,
	parameter int HEADER_BYTES = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Request side
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   command,
	input  logic [ffha_pkg::REQ_W-1:0]             request_size,
	input  logic [ffha_pkg::ADDR_W-1:0]            block_address,
	// Result side
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output logic [ffha_pkg::ADDR_W-1:0]            res_addr,
	output logic                                   res_ok,
	// Header memory
	output logic                                   mem_we,
	output logic [$clog2(HEAP_BYTES/8)-1:0]        mem_waddr,
	output logic [$clog2(HEAP_BYTES+1):0]          mem_wdata,
	output logic [$clog2(HEAP_BYTES/8)-1:0]        mem_raddr,
	input  logic [$clog2(HEAP_BYTES+1):0]          mem_rdata,
	// Evaluation unit
	output logic [$clog2(HEAP_BYTES)+1:0]          u_pos,
	output logic [$clog2(HEAP_BYTES+1)-1:0]        u_size_a,
	output logic [$clog2(HEAP_BYTES+1)-1:0]        u_rsize,
	output logic                                   u_rfree,
	output logic [ffha_pkg::WANT_W-1:0]            u_want,
	output logic [((($clog2(HEAP_BYTES)+2) > ffha_pkg::WANT_W) ?
		($clog2(HEAP_BYTES)+2) : ffha_pkg::WANT_W)-1:0] u_want_split,
	input  logic [$clog2(HEAP_BYTES)+1:0]          u_nxt_pos,
	input  logic [$clog2(HEAP_BYTES)+1:0]          u_rest_pos,
	input  logic [$clog2(HEAP_BYTES+1)-1:0]        u_rest_size,
	input  logic [$clog2(HEAP_BYTES+1)-1:0]        u_grown,
	input  ffha_pkg::ffha_flags_t                  u_flags
);
	import ffha_pkg::*;

	localparam int PW = $clog2(HEAP_BYTES) + 2;
	localparam int SW = $clog2(HEAP_BYTES + 1);
	localparam int AW = $clog2(HEAP_BYTES / 8);
	localparam int CW = (PW > WANT_W) ? PW : WANT_W;

	localparam logic [3:0] ST_INIT = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_AS   = 4'd2;   // alloc setup, read first header
	localparam logic [3:0] ST_AE   = 4'd3;   // alloc evaluate one header a cycle
	localparam logic [3:0] ST_AW1  = 4'd4;   // write allocated header
	localparam logic [3:0] ST_AW2  = 4'd5;   // write split-off header
	localparam logic [3:0] ST_FRD  = 4'd6;   // free, read own header
	localparam logic [3:0] ST_FB   = 4'd7;   // capture own size
	localparam logic [3:0] ST_FNX  = 4'd8;   // locate and read next header
	localparam logic [3:0] ST_FN   = 4'd9;   // absorb next block if free
	localparam logic [3:0] ST_FWR  = 4'd10;  // write merged header
	localparam logic [3:0] ST_DONE = 4'd11;

	logic [3:0]          state_q;
	logic [PW-1:0]       pos_q;
	logic [WANT_W-1:0]   want_q;
	logic [CW-1:0]       want_split_q;
	logic [SW-1:0]       bsize_q;
	logic [SW-1:0]       wsize_q;
	logic [PW-1:0]       rest_pos_q;
	logic [SW-1:0]       rest_size_q;
	logic                rest_ok_q;
	logic [ADDR_W-1:0]   res_addr_q;
	logic                res_ok_q;

	logic [SW-1:0]       rsize;
	logic                rfree;
	logic [CW-1:0]       free_pos;
	logic [CW-1:0]       hdr_end;

	assign rsize = mem_rdata[SW-1:0];
	assign rfree = mem_rdata[SW];

	assign free_pos = CW'(block_address) - CW'(HEADER_BYTES);
	assign hdr_end  = CW'(pos_q) + CW'(HEADER_BYTES);

	// Drive the evaluation unit
	assign u_pos        = pos_q;
	assign u_size_a     = (state_q == ST_AE) ? rsize : bsize_q;
	assign u_rsize      = rsize;
	assign u_rfree      = rfree;
	assign u_want       = want_q;
	assign u_want_split = want_split_q;

	// Read address: follow the chain while walking, else own header
	assign mem_raddr = ((state_q == ST_AE) || (state_q == ST_FNX)) ?
		u_nxt_pos[AW+2:3] : pos_q[AW+2:3];

	// Header writes
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q[AW+2:3];
		mem_wdata = {1'b0, bsize_q};
		unique case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = {1'b1, SW'(HEAP_BYTES - HEADER_BYTES)};
			end
			ST_AW1: begin
				mem_we    = 1'b1;
				mem_wdata = {1'b0, wsize_q};
			end
			ST_AW2: begin
				mem_we    = rest_ok_q;
				mem_waddr = rest_pos_q[AW+2:3];
				mem_wdata = {1'b1, rest_size_q};
			end
			ST_FWR: begin
				mem_we    = 1'b1;
				mem_wdata = {1'b1, bsize_q};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res_addr  = res_addr_q;
	assign res_ok    = res_ok_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						res_addr_q <= '0;
						if (command == CMD_ALLOC) begin
							pos_q  <= '0;
							want_q <= (WANT_W'(request_size) + WANT_W'(GRANULE_MASK)) &
								~WANT_W'(GRANULE_MASK);
							if (request_size == '0) begin
								res_ok_q <= 1'b0;
								state_q  <= ST_DONE;
							end else begin
								state_q <= ST_AS;
							end
						end else if (block_address == '0) begin
							// null free: nothing to do
							res_ok_q <= 1'b1;
							state_q  <= ST_DONE;
						end else if ((CW'(block_address) < CW'(HEADER_BYTES)) ||
							(free_pos >= CW'(HEAP_BYTES))) begin
							res_ok_q <= 1'b0;
							state_q  <= ST_DONE;
						end else begin
							pos_q   <= PW'(free_pos);
							state_q <= ST_FRD;
						end
					end
				end
				ST_AS: begin
					want_split_q <= CW'(want_q) + CW'(HEADER_BYTES) + CW'(MIN_SPLIT);
					state_q      <= ST_AE;
				end
				ST_AE: begin
					if (u_flags.fit) begin
						wsize_q     <= u_flags.split ? SW'(want_q) : rsize;
						rest_pos_q  <= u_rest_pos;
						rest_size_q <= u_rest_size;
						rest_ok_q   <= u_flags.split && u_flags.rest_in;
						res_addr_q  <= ADDR_W'(hdr_end);
						res_ok_q    <= 1'b1;
						state_q     <= ST_AW1;
					end else if (!u_flags.nxt_in) begin
						res_ok_q <= 1'b0;
						state_q  <= ST_DONE;
					end else begin
						pos_q <= u_nxt_pos;
					end
				end
				ST_AW1: begin
					state_q <= ST_AW2;
				end
				ST_AW2: begin
					state_q <= ST_DONE;
				end
				ST_FRD: begin
					state_q <= ST_FB;
				end
				ST_FB: begin
					bsize_q <= rsize;
					state_q <= ST_FNX;
				end
				ST_FNX: begin
					state_q <= u_flags.nxt_in ? ST_FN : ST_FWR;
				end
				ST_FN: begin
					if (rfree) begin
						bsize_q <= u_grown;
						state_q <= ST_FNX;
					end else begin
						state_q <= ST_FWR;
					end
				end
				ST_FWR: begin
					res_ok_q <= 1'b1;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/ffha_chk.sv
module ffha_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [9:0] payload_address,
	input logic       success
);

	// Stalled result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Stalled result payload holds
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(payload_address) && $stable(success))
		else $error("result payload changed while stalled");

	// Failed results report a null address
	a_fail_null: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !success |-> payload_address == 10'd0)
		else $error("failed request returned a nonzero address");

	// One item at a time: busy right after each input transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in progress");

endmodule

bind first_fit_heap_allocator_top ffha_chk u_ffha_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.payload_address(payload_address),
	.success        (success)
);

// File: bench/tb_first_fit_heap_allocator_top.sv
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator_top;
	import ffha_pkg::*;

	localparam int HEAP_BYTES    = 1024;
	localparam int HEADER_BYTES  = 16;
	localparam int SLOT_COUNT    = HEAP_BYTES / 8;
	localparam int SETTLE_CYCLES = 150;
	localparam int HOLD_OFF_SPAN = 400;
	localparam int MAX_PRINTED   = 60;

	typedef struct packed {
		logic [ADDR_W-1:0] payload_address;
		logic              success;
	} heap_reply_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              command;
	logic [REQ_W-1:0]  request_size;
	logic [ADDR_W-1:0] block_address;
	logic              out_valid;
	logic              out_stall;
	logic [ADDR_W-1:0] payload_address;
	logic              success;

	// Predicted heap: one header per 8-byte slot, plus a mark for slots ever written
	int unsigned slot_bytes [SLOT_COUNT];
	bit          heap_free [SLOT_COUNT];
	bit          heap_written [SLOT_COUNT];
	bit          touched_blank;

	heap_reply_t       pending_replies [$];
	logic [ADDR_W-1:0] live_blocks [$];

	bit quiet;
	int hold_off_left;
	int error_count;
	int results_checked;
	int allocs_granted;
	int allocs_refused;
	int frees_done;
	int frees_ignored;
	int peak_live;

	first_fit_heap_allocator_top #(
		.HEAP_BYTES   (HEAP_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.request_size    (request_size),
		.block_address   (block_address),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.payload_address (payload_address),
		.success         (success)
	);

	always #5 clk = ~clk;

	// Guard against a hung block
	initial begin
		#12_000_000;
		$display("Timeout: pending results %0d", pending_replies.size());
		$display("Regression FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		// keep the log short when the block is badly off
		if (error_count <= MAX_PRINTED)
			$display("MISMATCH @%0t: %s", $time, what);
	endtask

	// Slot reads note any touch of a header that was never written
	function automatic int unsigned slot_size(input int unsigned pos);
		if (!heap_written[pos >> 3])
			touched_blank = 1'b1;
		return slot_bytes[pos >> 3];
	endfunction

	function automatic bit slot_is_free(input int unsigned pos);
		if (!heap_written[pos >> 3])
			touched_blank = 1'b1;
		return heap_free[pos >> 3];
	endfunction

	// First-fit walk from offset 0, splitting when the tail can hold a block
	function automatic heap_reply_t predict_alloc(input int unsigned req);
		heap_reply_t reply;
		int unsigned want;
		int unsigned pos;
		int unsigned rest_pos;
		int unsigned rest_size;
		reply = '0;
		if (req == 0)
			return reply;
		want = (req + GRANULE_MASK) & ~GRANULE_MASK;
		pos = 0;
		while (pos < HEAP_BYTES) begin
			if (slot_is_free(pos) && slot_size(pos) >= want) begin
				if (slot_bytes[pos >> 3] >= want + HEADER_BYTES + MIN_SPLIT) begin
					rest_pos = pos + HEADER_BYTES + want;
					rest_size = slot_bytes[pos >> 3] - want - HEADER_BYTES;
					slot_bytes[pos >> 3] = want;
					if (rest_pos < HEAP_BYTES) begin
						slot_bytes[rest_pos >> 3] = rest_size;
						heap_free[rest_pos >> 3] = 1'b1;
						heap_written[rest_pos >> 3] = 1'b1;
					end
				end
				heap_free[pos >> 3] = 1'b0;
				reply.payload_address = ADDR_W'(pos + HEADER_BYTES);
				reply.success = 1'b1;
				return reply;
			end
			pos = pos + HEADER_BYTES + slot_size(pos);
		end
		return reply;
	endfunction

	// Mark free, then absorb each directly following free block
	function automatic heap_reply_t predict_free(input int unsigned addr);
		heap_reply_t reply;
		int unsigned pos;
		int unsigned nxt;
		int unsigned grown;
		reply = '0;
		if (addr == 0) begin
			reply.success = 1'b1;
			return reply;
		end
		if (addr < HEADER_BYTES)
			return reply;
		pos = addr - HEADER_BYTES;
		if (pos >= HEAP_BYTES)
			return reply;
		if (!heap_written[pos >> 3])
			touched_blank = 1'b1;
		heap_free[pos >> 3] = 1'b1;
		nxt = pos + HEADER_BYTES + slot_bytes[pos >> 3];
		while (nxt < HEAP_BYTES && slot_is_free(nxt)) begin
			grown = slot_bytes[pos >> 3] + HEADER_BYTES + slot_size(nxt);
			if (grown > HEAP_BYTES)
				grown = HEAP_BYTES;
			slot_bytes[pos >> 3] = grown;
			nxt = pos + HEADER_BYTES + slot_bytes[pos >> 3];
		end
		reply.success = 1'b1;
		return reply;
	endfunction

	// Apply a request to the predicted heap; back it out if it would read a
	// never-written header or leave the block chain from offset 0 through one
	function automatic bit plan_request(input logic cmd, input int unsigned size,
			input int unsigned addr, output heap_reply_t reply);
		int unsigned saved_size [SLOT_COUNT];
		bit          saved_free [SLOT_COUNT];
		bit          saved_written [SLOT_COUNT];
		int unsigned pos;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			saved_size[i] = slot_bytes[i];
			saved_free[i] = heap_free[i];
			saved_written[i] = heap_written[i];
		end
		touched_blank = 1'b0;
		if (cmd == CMD_ALLOC)
			reply = predict_alloc(size);
		else
			reply = predict_free(addr);
		pos = 0;
		while (pos < HEAP_BYTES)
			pos = pos + HEADER_BYTES + slot_size(pos);
		if (touched_blank) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_bytes[i] = saved_size[i];
				heap_free[i] = saved_free[i];
				heap_written[i] = saved_written[i];
			end
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// Offer one request until the block takes it, then queue its expected result
	task automatic send_request(input logic cmd, input logic [REQ_W-1:0] size,
			input logic [ADDR_W-1:0] addr, output bit sent);
		heap_reply_t reply;
		sent = plan_request(cmd, size, addr, reply);
		if (!sent)
			return;
		if (cmd == CMD_ALLOC && reply.success) begin
			live_blocks.push_back(reply.payload_address);
			if (live_blocks.size() > peak_live)
				peak_live = live_blocks.size();
		end
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 6) begin
			in_valid      <= 1'b0;
			command       <= 1'($urandom);
			request_size  <= REQ_W'($urandom);
			block_address <= ADDR_W'($urandom);
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		command       <= cmd;
		request_size  <= size;
		block_address <= addr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_replies.push_back(reply);
		if (cmd == CMD_ALLOC) begin
			if (reply.success)
				allocs_granted++;
			else
				allocs_refused++;
		end else if (reply.success) begin
			frees_done++;
		end else begin
			frees_ignored++;
		end
	endtask

	task automatic send_alloc(input int unsigned size);
		bit sent;
		send_request(CMD_ALLOC, REQ_W'(size), ADDR_W'($urandom), sent);
	endtask

	task automatic send_free(input int unsigned addr);
		bit sent;
		send_request(CMD_FREE, REQ_W'($urandom), ADDR_W'(addr), sent);
	endtask

	// Drop valid and hold off until every expected result has arrived
	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	// Mostly small allocations and frees of live blocks, some junk and stray frees
	task automatic send_random_request();
		int unsigned pick;
		int unsigned sel;
		int unsigned slot;
		int idx;
		logic cmd;
		logic [REQ_W-1:0] size;
		logic [ADDR_W-1:0] addr;
		bit sent;
		sent = 1'b0;
		for (int tries = 0; tries < 8 && !sent; tries++) begin
			size = REQ_W'($urandom);
			addr = ADDR_W'($urandom);
			idx = -1;
			pick = $urandom_range(99);
			if (live_blocks.size() > 24 && pick < 50)
				pick += 50;
			if (pick < 55 || (live_blocks.size() == 0 && pick < 80)) begin
				cmd = CMD_ALLOC;
				sel = $urandom_range(99);
				if (sel < 70)
					size = REQ_W'($urandom_range(64, 1));
				else if (sel < 88)
					size = REQ_W'($urandom_range(400, 65));
				else if (sel < 93)
					size = REQ_W'($urandom_range(HEAP_BYTES - HEADER_BYTES, 401));
				else if (sel < 96)
					size = '0;
				// otherwise keep the full-range value, nearly always refused
			end else begin
				cmd = CMD_FREE;
				if (pick < 85 && live_blocks.size() != 0) begin
					idx = $urandom_range(live_blocks.size() - 1);
					addr = live_blocks[idx];
				end else if (pick < 89) begin
					addr = '0;
				end else if (pick < 93) begin
					addr = ADDR_W'($urandom_range(HEADER_BYTES - 1, 1));
				end else begin
					// stray free on some slot, sometimes off the 8-byte grid
					slot = $urandom_range(SLOT_COUNT - 1);
					addr = ADDR_W'(slot * 8 + HEADER_BYTES +
						(($urandom_range(3) == 0) ? $urandom_range(7) : 0));
				end
			end
			send_request(cmd, size, addr, sent);
			if (sent && idx >= 0)
				live_blocks.delete(idx);
		end
		if (!sent)
			send_alloc($urandom_range(64, 1));
	endtask

	// Refusals, exact fits, splits, coalescing, null and stray frees
	task automatic test_directed_cases();
		send_alloc(0);
		send_alloc(65535);
		send_alloc(HEAP_BYTES - HEADER_BYTES + 1);
		send_alloc(1);
		send_alloc(8);
		send_free(0);
		send_free(1);
		send_free(HEADER_BYTES - 1);
		send_free(16);
		send_free(40);
		// stale header left inside the merged block
		send_free(64);
		send_alloc(984);
		send_alloc(8);
		send_free(40);
		send_free(16);
		send_alloc(HEAP_BYTES - HEADER_BYTES);
		send_free(16);
		// split leaving the smallest tail block at the heap end
		send_alloc(984);
		send_alloc(8);
		send_free(1023);
		send_free(1016);
		send_free(16);
		live_blocks.delete();
	endtask

	task automatic test_random_traffic(input int count);
		for (int i = 0; i < count; i++) begin
			send_random_request();
			if ($urandom_range(49) == 0)
				wait_for_results();
		end
	endtask

	task automatic test_unthrottled_stream(input int count);
		quiet = 1'b1;
		for (int i = 0; i < count; i++)
			send_random_request();
		wait_for_results();
		quiet = 1'b0;
	endtask

	// Hold the result side while requests keep coming, so the input backs up
	task automatic test_output_backpressure();
		quiet = 1'b1;
		hold_off_left = HOLD_OFF_SPAN;
		for (int i = 0; i < 25; i++)
			send_random_request();
		wait_for_results();
		quiet = 1'b0;
	endtask

	// Result side: random stalls, or a counted hold-off when one is requested
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			out_stall <= 1'b1;
			hold_off_left <= hold_off_left - 1;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < 6);
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin : check_replies
		heap_reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				report_mismatch($sformatf("unexpected result addr %0d success %0b",
					payload_address, success));
			end else begin
				want = pending_replies.pop_front();
				results_checked++;
				if (payload_address !== want.payload_address)
					report_mismatch($sformatf("payload_address %0d, expected %0d",
						payload_address, want.payload_address));
				if (success !== want.success)
					report_mismatch($sformatf("success %0b, expected %0b",
						success, want.success));
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_ALLOC;
		request_size = '0;
		block_address = '0;
		out_stall = 1'b0;
		quiet = 1'b0;
		hold_off_left = 0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slot_bytes[i] = 0;
			heap_free[i] = 1'b0;
			heap_written[i] = 1'b0;
		end
		slot_bytes[0] = HEAP_BYTES - HEADER_BYTES;
		heap_free[0] = 1'b1;
		heap_written[0] = 1'b1;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		wait_for_results();
		test_random_traffic(1000);
		wait_for_results();
		test_unthrottled_stream(300);
		test_output_backpressure();
		test_random_traffic(425);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d grants, %0d refusals, %0d frees, %0d ignored frees",
			allocs_granted, allocs_refused, frees_done, frees_ignored);
		$display("Checked %0d results, up to %0d live blocks, %0d mismatches",
			results_checked, peak_live, error_count);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/ffha_pkg.sv
rtl/core/ffha_ram.sv
rtl/core/ffha_unit.sv
rtl/core/ffha_ctrl.sv
rtl/core/first_fit_heap_allocator_top.sv
rtl/core/ffha_chk.sv
bench/tb_first_fit_heap_allocator_top.sv
